/* rtl/hsv_to_rgb_pwm_duty_unit_defines.svh */
// assertion helpers used by the checker file
`ifndef HSV_TO_RGB_PWM_DUTY_UNIT_DEFINES_SVH
`define HSV_TO_RGB_PWM_DUTY_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HSVRGB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsvrgb check failed");

// next-cycle implication, disabled while in reset
`define HSVRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsvrgb check failed");

`endif

/* rtl/hsvrgb_pkg.sv */
package hsvrgb_pkg;

    localparam int unsigned HUE_W      = 9;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned DUTY_W     = 16;
    localparam int unsigned REM_W      = 6;
    localparam int unsigned NUM_W      = 14;
    localparam int unsigned PROD_W     = 20;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

    localparam int unsigned HUE_RANGE   = 360;
    localparam int unsigned SECTOR_SPAN = 60;
    localparam int unsigned PCT_MAX     = 100;
    localparam int unsigned PCT_SQ      = 10000;
    localparam int unsigned LEVEL_MAX   = 255;

    // 5*r/3 by reciprocal, exact for r below 60
    localparam int unsigned FRAC_MUL   = 5 * 683;
    localparam int unsigned FRAC_SHIFT = 11;
    // x/100, exact for x up to 25500
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int unsigned DIV100_SHIFT = 19;
    // x/10000, exact for x up to 1000000
    localparam int unsigned DIV10K_MUL   = 1717987;
    localparam int unsigned DIV10K_SHIFT = 34;
    // x/255, exact for x up to 255*65535
    localparam int unsigned DIV255_MUL   = 16843010;
    localparam int unsigned DIV255_SHIFT = 32;

    localparam logic [DUTY_W-1:0]    FULL_DUTY_RESET = 16'd8191;
    localparam logic [REG_IDX_W-1:0] REG_FULL_DUTY   = 1'd0;

    typedef logic [2:0] sector_t;

    localparam sector_t SEC_RED_YEL = 3'd0;
    localparam sector_t SEC_YEL_GRN = 3'd1;
    localparam sector_t SEC_GRN_CYN = 3'd2;
    localparam sector_t SEC_CYN_BLU = 3'd3;
    localparam sector_t SEC_BLU_MAG = 3'd4;
    localparam sector_t SEC_MAG_RED = 3'd5;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
    } hsv_t;

    typedef struct packed {
        sector_t          sector;
        logic [PCT_W-1:0] v;
        logic [PCT_W-1:0] p;
        logic [PCT_W-1:0] q;
        logic [PCT_W-1:0] t;
    } pqt_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } rgb_level_t;

    typedef struct packed {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
    } rgb_duty_t;

    // pipeline control handed from the top to every stage block
    typedef struct packed {
        logic advance;
    } pipe_ctrl_t;

endpackage

/* rtl/hsvrgb_in_if.sv */
interface hsvrgb_in_if import hsvrgb_pkg::*;;
    logic               valid;
    logic               ready;
    logic [HUE_W-1:0]   hue_degrees;
    logic [PCT_W-1:0]   saturation_pct;
    logic [PCT_W-1:0]   brightness_pct;

    modport source (
        output valid, hue_degrees, saturation_pct, brightness_pct,
        input  ready
    );
    modport sink (
        input  valid, hue_degrees, saturation_pct, brightness_pct,
        output ready
    );
endinterface

/* rtl/hsvrgb_out_if.sv */
interface hsvrgb_out_if import hsvrgb_pkg::*;;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [DUTY_W-1:0]  red_duty;
    logic [DUTY_W-1:0]  green_duty;
    logic [DUTY_W-1:0]  blue_duty;

    modport source (
        output valid, red_level, green_level, blue_level,
               red_duty, green_duty, blue_duty,
        input  ready
    );
    modport sink (
        input  valid, red_level, green_level, blue_level,
               red_duty, green_duty, blue_duty,
        output ready
    );
endinterface

/* rtl/hsvrgb_apb_regs.sv */
module hsvrgb_apb_regs
    import hsvrgb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [DUTY_W-1:0]     full_duty
);

    logic [DUTY_W-1:0]    full_duty_reg;
    logic [DUTY_W-1:0]    full_duty_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // byte address bits below the word are ignored
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        full_duty_next = full_duty_reg;
        if (wr_en && (reg_idx == REG_FULL_DUTY))
        begin
            full_duty_next = pwdata[DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_duty_reg <= FULL_DUTY_RESET;
        end
        else
        begin
            full_duty_reg <= full_duty_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_FULL_DUTY)
        begin
            prdata = {{(APB_DATA_W-DUTY_W){1'b0}}, full_duty_reg};
        end
    end

    assign pready    = 1'b1;
    assign full_duty = full_duty_reg;

endmodule

/* rtl/hsvrgb_pqt.sv */
module hsvrgb_pqt
    import hsvrgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pipe_ctrl_t ctrl,
    input  logic       in_valid,
    input  hsv_t       in_hsv,
    output logic       out_valid,
    output pqt_t       out_pqt
);

    // stage 1: hue wrap and percent clamp
    logic [HUE_W-1:0] s1_hue_next;
    logic [PCT_W-1:0] s1_sat_next;
    logic [PCT_W-1:0] s1_val_next;
    logic             s1_valid_reg;
    logic [HUE_W-1:0] s1_hue_reg;
    logic [PCT_W-1:0] s1_sat_reg;
    logic [PCT_W-1:0] s1_val_reg;

    assign s1_hue_next = (in_hsv.hue >= HUE_W'(HUE_RANGE)) ?
                         in_hsv.hue - HUE_W'(HUE_RANGE) : in_hsv.hue;
    assign s1_sat_next = (in_hsv.sat > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : in_hsv.sat;
    assign s1_val_next = (in_hsv.val > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : in_hsv.val;

    // stage 2: sector and offset inside the sector
    sector_t          s2_sector_next;
    logic [HUE_W-1:0] s2_base;
    logic [REM_W-1:0] s2_rem_next;
    logic             s2_valid_reg;
    sector_t          s2_sector_reg;
    logic [REM_W-1:0] s2_rem_reg;
    logic [PCT_W-1:0] s2_sat_reg;
    logic [PCT_W-1:0] s2_val_reg;

    always_comb
    begin
        if (s1_hue_reg >= HUE_W'(5 * SECTOR_SPAN))
        begin
            s2_sector_next = SEC_MAG_RED;
            s2_base        = HUE_W'(5 * SECTOR_SPAN);
        end
        else if (s1_hue_reg >= HUE_W'(4 * SECTOR_SPAN))
        begin
            s2_sector_next = SEC_BLU_MAG;
            s2_base        = HUE_W'(4 * SECTOR_SPAN);
        end
        else if (s1_hue_reg >= HUE_W'(3 * SECTOR_SPAN))
        begin
            s2_sector_next = SEC_CYN_BLU;
            s2_base        = HUE_W'(3 * SECTOR_SPAN);
        end
        else if (s1_hue_reg >= HUE_W'(2 * SECTOR_SPAN))
        begin
            s2_sector_next = SEC_GRN_CYN;
            s2_base        = HUE_W'(2 * SECTOR_SPAN);
        end
        else if (s1_hue_reg >= HUE_W'(SECTOR_SPAN))
        begin
            s2_sector_next = SEC_YEL_GRN;
            s2_base        = HUE_W'(SECTOR_SPAN);
        end
        else
        begin
            s2_sector_next = SEC_RED_YEL;
            s2_base        = '0;
        end
    end

    assign s2_rem_next = REM_W'(s1_hue_reg - s2_base);

    // stage 3: fraction f = 5*rem/3, on a 0..98 scale
    localparam int unsigned FRAC_PROD_W = REM_W + 12;
    logic [FRAC_PROD_W-1:0] s3_frac_prod;
    logic                   s3_valid_reg;
    sector_t                s3_sector_reg;
    logic [PCT_W-1:0]       s3_frac_reg;
    logic [PCT_W-1:0]       s3_sat_reg;
    logic [PCT_W-1:0]       s3_val_reg;

    assign s3_frac_prod = FRAC_PROD_W'(s2_rem_reg) * FRAC_PROD_W'(FRAC_MUL);

    // stage 4: numerators for p, q and t
    logic [NUM_W-1:0] s4_fs;
    logic [PCT_W-1:0] s4_frac_inv;
    logic [NUM_W-1:0] s4_ts;
    logic             s4_valid_reg;
    sector_t          s4_sector_reg;
    logic [PCT_W-1:0] s4_val_reg;
    logic [PCT_W-1:0] s4_pnum_reg;
    logic [NUM_W-1:0] s4_qnum_reg;
    logic [NUM_W-1:0] s4_tnum_reg;

    assign s4_fs       = NUM_W'(s3_frac_reg) * NUM_W'(s3_sat_reg);
    assign s4_frac_inv = PCT_W'(PCT_MAX) - s3_frac_reg;
    assign s4_ts       = NUM_W'(s3_sat_reg) * NUM_W'(s4_frac_inv);

    // stage 5: scale by brightness
    logic             s5_valid_reg;
    sector_t          s5_sector_reg;
    logic [PCT_W-1:0] s5_val_reg;
    logic [NUM_W-1:0] s5_pv_reg;
    logic [PROD_W-1:0] s5_qv_reg;
    logic [PROD_W-1:0] s5_tv_reg;

    // stage 6: divide by 100 and 10000
    localparam int unsigned P_PROD_W = NUM_W + 13;
    localparam int unsigned Q_PROD_W = PROD_W + 21;
    logic [P_PROD_W-1:0] s6_p_prod;
    logic [Q_PROD_W-1:0] s6_q_prod;
    logic [Q_PROD_W-1:0] s6_t_prod;
    logic                s6_valid_reg;
    pqt_t                s6_pqt_reg;

    assign s6_p_prod = P_PROD_W'(s5_pv_reg) * P_PROD_W'(DIV100_MUL);
    assign s6_q_prod = Q_PROD_W'(s5_qv_reg) * Q_PROD_W'(DIV10K_MUL);
    assign s6_t_prod = Q_PROD_W'(s5_tv_reg) * Q_PROD_W'(DIV10K_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            s1_hue_reg <= s1_hue_next;
            s1_sat_reg <= s1_sat_next;
            s1_val_reg <= s1_val_next;

            s2_sector_reg <= s2_sector_next;
            s2_rem_reg    <= s2_rem_next;
            s2_sat_reg    <= s1_sat_reg;
            s2_val_reg    <= s1_val_reg;

            s3_sector_reg <= s2_sector_reg;
            s3_frac_reg   <= s3_frac_prod[FRAC_SHIFT +: PCT_W];
            s3_sat_reg    <= s2_sat_reg;
            s3_val_reg    <= s2_val_reg;

            s4_sector_reg <= s3_sector_reg;
            s4_val_reg    <= s3_val_reg;
            s4_pnum_reg   <= PCT_W'(PCT_MAX) - s3_sat_reg;
            s4_qnum_reg   <= NUM_W'(PCT_SQ) - s4_fs;
            s4_tnum_reg   <= NUM_W'(PCT_SQ) - s4_ts;

            s5_sector_reg <= s4_sector_reg;
            s5_val_reg    <= s4_val_reg;
            s5_pv_reg     <= NUM_W'(s4_val_reg) * NUM_W'(s4_pnum_reg);
            s5_qv_reg     <= PROD_W'(s4_val_reg) * PROD_W'(s4_qnum_reg);
            s5_tv_reg     <= PROD_W'(s4_val_reg) * PROD_W'(s4_tnum_reg);

            s6_pqt_reg.sector <= s5_sector_reg;
            s6_pqt_reg.v      <= s5_val_reg;
            s6_pqt_reg.p      <= s6_p_prod[DIV100_SHIFT +: PCT_W];
            s6_pqt_reg.q      <= s6_q_prod[DIV10K_SHIFT +: PCT_W];
            s6_pqt_reg.t      <= s6_t_prod[DIV10K_SHIFT +: PCT_W];
        end
    end

    assign out_valid = s6_valid_reg;
    assign out_pqt   = s6_pqt_reg;

endmodule

/* rtl/hsvrgb_level.sv */
module hsvrgb_level
    import hsvrgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pipe_ctrl_t ctrl,
    input  logic       in_valid,
    input  pqt_t       in_pqt,
    output logic       out_valid,
    output rgb_level_t out_level
);

    localparam int unsigned SCALED_W = PCT_W + LEVEL_W;
    localparam int unsigned LVL_PROD_W = SCALED_W + 13;

    logic [PCT_W-1:0]    red_pct;
    logic [PCT_W-1:0]    green_pct;
    logic [PCT_W-1:0]    blue_pct;
    logic                s7_valid_reg;
    logic [SCALED_W-1:0] s7_red_reg;
    logic [SCALED_W-1:0] s7_green_reg;
    logic [SCALED_W-1:0] s7_blue_reg;
    logic [LVL_PROD_W-1:0] red_prod;
    logic [LVL_PROD_W-1:0] green_prod;
    logic [LVL_PROD_W-1:0] blue_prod;
    logic                s8_valid_reg;
    rgb_level_t          s8_level_reg;

    always_comb
    begin
        case (in_pqt.sector)
            SEC_RED_YEL:
            begin
                red_pct = in_pqt.v; green_pct = in_pqt.t; blue_pct = in_pqt.p;
            end
            SEC_YEL_GRN:
            begin
                red_pct = in_pqt.q; green_pct = in_pqt.v; blue_pct = in_pqt.p;
            end
            SEC_GRN_CYN:
            begin
                red_pct = in_pqt.p; green_pct = in_pqt.v; blue_pct = in_pqt.t;
            end
            SEC_CYN_BLU:
            begin
                red_pct = in_pqt.p; green_pct = in_pqt.q; blue_pct = in_pqt.v;
            end
            SEC_BLU_MAG:
            begin
                red_pct = in_pqt.t; green_pct = in_pqt.p; blue_pct = in_pqt.v;
            end
            default:
            begin
                red_pct = in_pqt.v; green_pct = in_pqt.p; blue_pct = in_pqt.q;
            end
        endcase
    end

    assign red_prod   = LVL_PROD_W'(s7_red_reg) * LVL_PROD_W'(DIV100_MUL);
    assign green_prod = LVL_PROD_W'(s7_green_reg) * LVL_PROD_W'(DIV100_MUL);
    assign blue_prod  = LVL_PROD_W'(s7_blue_reg) * LVL_PROD_W'(DIV100_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            s7_valid_reg <= in_valid;
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            s7_red_reg   <= SCALED_W'(red_pct) * SCALED_W'(LEVEL_MAX);
            s7_green_reg <= SCALED_W'(green_pct) * SCALED_W'(LEVEL_MAX);
            s7_blue_reg  <= SCALED_W'(blue_pct) * SCALED_W'(LEVEL_MAX);

            s8_level_reg.red   <= red_prod[DIV100_SHIFT +: LEVEL_W];
            s8_level_reg.green <= green_prod[DIV100_SHIFT +: LEVEL_W];
            s8_level_reg.blue  <= blue_prod[DIV100_SHIFT +: LEVEL_W];
        end
    end

    assign out_valid = s8_valid_reg;
    assign out_level = s8_level_reg;

endmodule

/* rtl/hsvrgb_duty.sv */
module hsvrgb_duty
    import hsvrgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_ctrl_t        ctrl,
    input  logic [DUTY_W-1:0] full_duty,
    input  logic              in_valid,
    input  rgb_level_t        in_level,
    output logic              out_valid,
    output rgb_level_t        out_level,
    output rgb_duty_t         out_duty
);

    localparam int unsigned RAW_W  = LEVEL_W + DUTY_W;
    localparam int unsigned RECIP_W = RAW_W + 25;

    logic               s9_valid_reg;
    rgb_level_t         s9_level_reg;
    logic [RAW_W-1:0]   s9_red_reg;
    logic [RAW_W-1:0]   s9_green_reg;
    logic [RAW_W-1:0]   s9_blue_reg;
    logic [RECIP_W-1:0] red_prod;
    logic [RECIP_W-1:0] green_prod;
    logic [RECIP_W-1:0] blue_prod;
    logic               s10_valid_reg;
    rgb_level_t         s10_level_reg;
    rgb_duty_t          s10_duty_reg;

    // divide by 255 through the reciprocal
    assign red_prod   = RECIP_W'(s9_red_reg) * RECIP_W'(DIV255_MUL);
    assign green_prod = RECIP_W'(s9_green_reg) * RECIP_W'(DIV255_MUL);
    assign blue_prod  = RECIP_W'(s9_blue_reg) * RECIP_W'(DIV255_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            s9_valid_reg  <= in_valid;
            s10_valid_reg <= s9_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            s9_level_reg <= in_level;
            s9_red_reg   <= RAW_W'(in_level.red) * RAW_W'(full_duty);
            s9_green_reg <= RAW_W'(in_level.green) * RAW_W'(full_duty);
            s9_blue_reg  <= RAW_W'(in_level.blue) * RAW_W'(full_duty);

            s10_level_reg      <= s9_level_reg;
            s10_duty_reg.red   <= red_prod[DIV255_SHIFT +: DUTY_W];
            s10_duty_reg.green <= green_prod[DIV255_SHIFT +: DUTY_W];
            s10_duty_reg.blue  <= blue_prod[DIV255_SHIFT +: DUTY_W];
        end
    end

    assign out_valid = s10_valid_reg;
    assign out_level = s10_level_reg;
    assign out_duty  = s10_duty_reg;

endmodule

/* rtl/hsv_to_rgb_pwm_duty_unit.sv */
// throughput: one beat per cycle while output beats are taken; ten register
// stages, each with at most one small multiply in series, advance together
// and hold when the output beat is not taken
// reset: valid bits of all stages clear, full_duty returns to 8191
module hsv_to_rgb_pwm_duty_unit
    import hsvrgb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    hsvrgb_in_if.sink             color_in,
    hsvrgb_out_if.source          color_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    pipe_ctrl_t        ctrl;
    logic [DUTY_W-1:0] full_duty;
    hsv_t              in_hsv;
    logic              pqt_valid;
    pqt_t              pqt;
    logic              level_valid;
    rgb_level_t        level;
    logic              out_valid;
    rgb_level_t        out_level;
    rgb_duty_t         out_duty;

    // the whole pipe moves unless the last stage holds an untaken beat
    assign ctrl.advance   = !out_valid || color_out.ready;
    assign color_in.ready = ctrl.advance;

    assign in_hsv.hue = color_in.hue_degrees;
    assign in_hsv.sat = color_in.saturation_pct;
    assign in_hsv.val = color_in.brightness_pct;

    hsvrgb_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .full_duty (full_duty)
    );

    hsvrgb_pqt u_pqt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_valid  (color_in.valid),
        .in_hsv    (in_hsv),
        .out_valid (pqt_valid),
        .out_pqt   (pqt)
    );

    hsvrgb_level u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_valid  (pqt_valid),
        .in_pqt    (pqt),
        .out_valid (level_valid),
        .out_level (level)
    );

    hsvrgb_duty u_duty (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .full_duty (full_duty),
        .in_valid  (level_valid),
        .in_level  (level),
        .out_valid (out_valid),
        .out_level (out_level),
        .out_duty  (out_duty)
    );

    assign color_out.valid       = out_valid;
    assign color_out.red_level   = out_level.red;
    assign color_out.green_level = out_level.green;
    assign color_out.blue_level  = out_level.blue;
    assign color_out.red_duty    = out_duty.red;
    assign color_out.green_duty  = out_duty.green;
    assign color_out.blue_duty   = out_duty.blue;

endmodule

/* rtl/hsvrgb_checker.sv */
`include "hsv_to_rgb_pwm_duty_unit_defines.svh"

module hsvrgb_checker
    import hsvrgb_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [LEVEL_W-1:0] red_level,
    input logic [LEVEL_W-1:0] green_level,
    input logic [LEVEL_W-1:0] blue_level,
    input logic [DUTY_W-1:0]  red_duty,
    input logic [DUTY_W-1:0]  green_duty,
    input logic [DUTY_W-1:0]  blue_duty,
    input logic               pready
);

    logic out_stall;
    logic in_beat;

    assign out_stall = out_valid && !out_ready;
    assign in_beat   = in_valid && in_ready;

    // a stalled output beat keeps its payload
    `HSVRGB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall,
        out_valid && $stable(red_level) && $stable(green_level) && $stable(blue_level)
        && $stable(red_duty) && $stable(green_duty) && $stable(blue_duty))

    // a stalled output takes no new beat
    `HSVRGB_ASSERT_NOW(a_backpressure, clk, rst_n, out_stall, !in_beat)

    // a dark color gives zero duty on every channel
    `HSVRGB_ASSERT_NOW(a_dark_duty, clk, rst_n,
        out_valid && (red_level == '0) && (green_level == '0) && (blue_level == '0),
        (red_duty == '0) && (green_duty == '0) && (blue_duty == '0))

    `HSVRGB_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, pready)

endmodule

bind hsv_to_rgb_pwm_duty_unit hsvrgb_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (color_in.valid),
    .in_ready    (color_in.ready),
    .out_valid   (color_out.valid),
    .out_ready   (color_out.ready),
    .red_level   (color_out.red_level),
    .green_level (color_out.green_level),
    .blue_level  (color_out.blue_level),
    .red_duty    (color_out.red_duty),
    .green_duty  (color_out.green_duty),
    .blue_duty   (color_out.blue_duty),
    .pready      (pready)
);
